>>> hdl/ssbs_pkg.sv
package ssbs_pkg;

  // Store geometry
  localparam int DEPTH      = 16;
  localparam int VALUE_BITS = 16;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // Operation codes on func
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  // Status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;        // capture value, set up pointer and search bounds
    logic ins_rd;      // read entry below insert pointer
    logic shift;       // move entry up one place, read next one down
    logic place;       // write value at insert pointer, grow store
    logic probe;       // read midpoint entry
    logic narrow;      // update search bounds after a miss
    logic finish;      // capture result fields
    logic fin_status;
    logic fin_found;
  } ssbs_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic full;
    logic ptr_zero;
    logic ptr_one;
    logic gt;          // read entry above value
    logic eq;          // read entry equals value
    logic range_empty; // search bounds crossed
  } ssbs_sts_t;

endpackage

>>> hdl/ssbs_dp.sv
module ssbs_dp
  import ssbs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  ssbs_cmd_t             cmd,
  input  logic [VALUE_BITS-1:0] grade_value,
  output ssbs_sts_t             sts,
  output logic                  status,
  output logic                  found,
  output logic [IDX_W-1:0]      position,
  output logic [VALUE_BITS-1:0] lowest,
  output logic [VALUE_BITS-1:0] highest,
  output logic [CNT_W-1:0]      count
);

  logic [VALUE_BITS-1:0] mem [DEPTH];
  logic [VALUE_BITS-1:0] rd_data;
  logic [VALUE_BITS-1:0] val;
  logic [CNT_W-1:0]      ptr;
  logic [CNT_W-1:0]      lo;
  logic [CNT_W-1:0]      hx;      // exclusive upper bound
  logic [IDX_W-1:0]      mid;

  logic [CNT_W-1:0]      ptr_m1;
  logic [CNT_W-1:0]      ptr_m2;
  logic [CNT_W-1:0]      span;
  logic [CNT_W-1:0]      mid_sum;
  logic [IDX_W-1:0]      mid_c;
  logic                  mem_we;
  logic [IDX_W-1:0]      wr_addr;
  logic [IDX_W-1:0]      rd_addr;
  logic [VALUE_BITS-1:0] wr_data;

  // Address arithmetic
  always_comb begin
    ptr_m1  = ptr - CNT_W'(1);
    ptr_m2  = ptr - CNT_W'(2);
    span    = hx - lo - CNT_W'(1);
    mid_sum = lo + (span >> 1);
    mid_c   = mid_sum[IDX_W-1:0];
    mem_we  = cmd.shift | cmd.place;
    wr_addr = ptr[IDX_W-1:0];
    wr_data = cmd.shift ? rd_data : val;
    if (cmd.probe) begin
      rd_addr = mid_c;
    end else if (cmd.shift) begin
      rd_addr = ptr_m2[IDX_W-1:0];
    end else begin
      rd_addr = ptr_m1[IDX_W-1:0];
    end
  end

  // Entry memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val <= grade_value;
      ptr <= count;
      lo  <= '0;
      hx  <= count;
    end
    if (cmd.shift) begin
      ptr <= ptr_m1;
    end
    if (cmd.probe) begin
      mid <= mid_c;
    end
    if (cmd.narrow) begin
      if (rd_data > val) begin
        hx <= {1'b0, mid};
      end else begin
        lo <= {1'b0, mid} + CNT_W'(1);
      end
    end
  end

  // Fill count and end values
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      lowest  <= '0;
      highest <= '0;
    end else if (cmd.place) begin
      count <= count + CNT_W'(1);
      if (ptr == '0) begin
        lowest <= val;
      end
      if (ptr == count) begin
        highest <= val;
      end
    end
  end

  // Result fields
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status   <= cmd.fin_status;
      found    <= cmd.fin_found;
      position <= cmd.fin_found ? mid : '0;
    end
  end

  assign sts.full        = (count == CNT_W'(DEPTH));
  assign sts.ptr_zero    = (ptr == '0);
  assign sts.ptr_one     = (ptr == CNT_W'(1));
  assign sts.gt          = (rd_data > val);
  assign sts.eq          = (rd_data == val);
  assign sts.range_empty = (lo >= hx);

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("fill count beyond depth");

  a_shift_ptr: assert property (@(posedge clk) disable iff (rst)
    cmd.shift |-> ptr != '0)
    else $error("shift below entry zero");

  a_place_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.place |-> !sts.full)
    else $error("write into full store");

  a_order: assert property (@(posedge clk) disable iff (rst)
    count != '0 |-> lowest <= highest)
    else $error("lowest above highest");

endmodule

>>> hdl/ssbs_ctrl.sv
module ssbs_ctrl
  import ssbs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      func,
  input  ssbs_sts_t sts,
  output ssbs_cmd_t cmd,
  output logic      busy,
  output logic      done
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_SRCH_CHK,
    ST_SRCH_CMP
  } state_t;

  state_t state, state_next;
  logic   busy_next;
  logic   done_next;

  // Next state and commands
  always_comb begin
    state_next = state;
    busy_next  = busy;
    done_next  = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (func == FUNC_INSERT && sts.full) begin
            cmd.finish     = 1'b1;
            cmd.fin_status = STATUS_FULL;
            done_next      = 1'b1;
          end else begin
            busy_next  = 1'b1;
            state_next = (func == FUNC_SEARCH) ? ST_SRCH_CHK : ST_INS_RD;
          end
        end
      end
      ST_INS_RD: begin
        if (sts.ptr_zero) begin
          cmd.place  = 1'b1;
          cmd.finish = 1'b1;
          busy_next  = 1'b0;
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cmd.ins_rd = 1'b1;
          state_next = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        if (sts.gt) begin
          cmd.shift = 1'b1;
          if (sts.ptr_one) begin
            state_next = ST_INS_RD;
          end
        end else begin
          cmd.place  = 1'b1;
          cmd.finish = 1'b1;
          busy_next  = 1'b0;
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_SRCH_CHK: begin
        if (sts.range_empty) begin
          cmd.finish = 1'b1;
          busy_next  = 1'b0;
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cmd.probe  = 1'b1;
          state_next = ST_SRCH_CMP;
        end
      end
      ST_SRCH_CMP: begin
        if (sts.eq) begin
          cmd.finish    = 1'b1;
          cmd.fin_found = 1'b1;
          busy_next     = 1'b0;
          done_next     = 1'b1;
          state_next    = ST_IDLE;
        end else begin
          cmd.narrow = 1'b1;
          state_next = ST_SRCH_CHK;
        end
      end
      default: begin
        busy_next  = 1'b0;
        state_next = ST_IDLE;
      end
    endcase
  end

  // State and registered handshake outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= busy_next;
      done  <= done_next;
    end
  end

  a_idle_not_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) == !busy)
    else $error("busy out of step with state");

  a_done_free: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_accept_moves: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || done)
    else $error("accepted transaction went nowhere");

endmodule

>>> hdl/sorted_store_with_binary_search.sv
// Channel   Direction  Handshake             Fields
// command   in         start, busy           func, grade_value
// result    out        done (one-cycle)      status, found, position,
//                                            lowest, highest, count
//
// Insert: each entry above the value moves up one place, then the value is
// written; an empty store takes it directly; a full store reports STATUS_FULL.
// Search: each probe reads the midpoint entry from the registered-read entry
// memory, then compares it and narrows the search bounds after a miss.
// Synchronous active-high reset empties the store; entry contents are not
// cleared, only the fill count and end values. A new command is taken in the
// cycle done is high. done lasts one cycle and the receiver cannot stall it.
module sorted_store_with_binary_search
  import ssbs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  func,
  input  logic [VALUE_BITS-1:0] grade_value,
  output logic                  done,
  output logic                  status,
  output logic                  found,
  output logic [IDX_W-1:0]      position,
  output logic [VALUE_BITS-1:0] lowest,
  output logic [VALUE_BITS-1:0] highest,
  output logic [CNT_W-1:0]      count
);

  ssbs_cmd_t cmd;
  ssbs_sts_t sts;

  ssbs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .func  (func),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  ssbs_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .grade_value (grade_value),
    .sts         (sts),
    .status      (status),
    .found       (found),
    .position    (position),
    .lowest      (lowest),
    .highest     (highest),
    .count       (count)
  );

endmodule
